FILE: rtl/core/hrgb_pkg.sv
// Shared constants for the hue to RGB color wheel.
package hrgb_pkg;

    // Configuration register indexes.
    localparam logic CFG_PALETTE_SELECT = 1'b0;
    localparam logic CFG_COLOR_SPEED    = 1'b1;

    // Palette codes.
    localparam logic PAL_SPECTRUM = 1'b0;
    localparam logic PAL_RAINBOW  = 1'b1;

    // Reset value of the speed register, 1.0 in signed Q8.8.
    localparam logic signed [15:0] COLOR_SPEED_RESET = 16'sd256;

    // Sector (spectrum) or section (rainbow) numbers.
    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;
    localparam logic [2:0] SECT_6 = 3'd6;
    localparam logic [2:0] SECT_7 = 3'd7;

    // Field widths of the stream payloads.
    localparam int TIME_W  = 32;
    localparam int PHASE_W = 16;
    localparam int LEVEL_W = 16;

    typedef logic [LEVEL_W-1:0] t_level;

endpackage

FILE: rtl/core/hue_to_rgb_color_wheel_unit.sv
// Hue to RGB color wheel: time and phase in, one Q8.8 RGB triple out per request.
//
// Each input request carries a time value (unsigned Q16.16) and a phase offset
// (Q0.16). The hue is the wrapped fraction of time * color_speed + phase, and it
// is mapped to RGB either by a six-sector spectrum wheel or by an eight-section
// rainbow palette. The datapath is three register stages: the speed multiplier,
// the hue sum with sector split, and the channel ramps into the output register.
// A request is accepted every clock while the output side keeps taking results,
// and its result passes the stage 1, stage 2 and output registers before it is
// offered on m_axis_tvalid; a stall on the output fills the three stages and then
// holds the input off.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata, by the
// user only while the block holds no request; the block does not enforce this.
module hue_to_rgb_color_wheel_unit #(
    parameter int HUE_FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] time_value, [47:32] phase_offset
    input  logic [47:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] red_level, [31:16] green_level, [47:32] blue_level
    output logic [47:0] m_axis_tdata
);

    localparam int HFB = HUE_FRACTION_BITS;
    localparam int LW  = HFB + 8;
    localparam int PROD_FRAC_BITS = 24;

    localparam logic [LW-1:0] LVL_255 = {8'd255, {HFB{1'b0}}};
    localparam logic [LW-1:0] LVL_171 = {8'd171, {HFB{1'b0}}};
    localparam logic [LW-1:0] LVL_170 = {8'd170, {HFB{1'b0}}};
    localparam logic [LW-1:0] LVL_85  = {8'd85,  {HFB{1'b0}}};

    // Configuration registers.
    logic                r_palette;
    logic signed [15:0]  r_color_speed;

    // Stage valids and handshake.
    logic r_v1;
    logic r_v2;
    logic r_out_valid;
    logic w_adv1;
    logic w_adv2;
    logic w_adv3;

    // Stage 1: scaled product and aligned phase.
    logic [hrgb_pkg::TIME_W-1:0]  w_time;
    logic [hrgb_pkg::PHASE_W-1:0] w_phase_in;
    logic signed [48:0]           w_prod;
    logic [HFB-1:0]               w_phase_al;
    logic [HFB-1:0]               r_scaled;
    logic [HFB-1:0]               r_phase;

    // Stage 2: sector and fraction.
    logic [HFB-1:0]   w_hue;
    logic [HFB+2:0]   w_h6;
    logic [2:0]       r_sector;
    logic [HFB-1:0]   r_frac;

    // Stage 3: channel ramps.
    logic [LW-1:0]    w_f;
    logic [LW-1:0]    w_up;
    logic [LW-1:0]    w_dn;
    logic [LW-1:0]    w_t;
    logic [LW-1:0]    w_w;
    logic [LW-1:0]    w_r;
    logic [LW-1:0]    w_g;
    logic [LW-1:0]    w_b;
    hrgb_pkg::t_level r_red;
    hrgb_pkg::t_level r_green;
    hrgb_pkg::t_level r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette     <= hrgb_pkg::PAL_SPECTRUM;
            r_color_speed <= hrgb_pkg::COLOR_SPEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hrgb_pkg::CFG_PALETTE_SELECT: r_palette     <= i_cfg_wdata[0];
                hrgb_pkg::CFG_COLOR_SPEED:    r_color_speed <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    assign w_adv3        = !r_out_valid || m_axis_tready;
    assign w_adv2        = !r_v2 || w_adv3;
    assign w_adv1        = !r_v1 || w_adv2;
    assign s_axis_tready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_out_valid <= r_v2;
            end
        end
    end

    assign w_time     = s_axis_tdata[31:0];
    assign w_phase_in = s_axis_tdata[47:32];
    assign w_prod     = r_color_speed * $signed({1'b0, w_time});

    generate
        if (HFB >= 16) begin : g_phase_wide
            assign w_phase_al = {w_phase_in, {(HFB-16){1'b0}}};
        end else begin : g_phase_narrow
            assign w_phase_al = w_phase_in[15 -: HFB];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_adv1 && s_axis_tvalid) begin
            // Floor to the hue format and drop the integer turns.
            r_scaled <= w_prod[PROD_FRAC_BITS-HFB +: HFB];
            r_phase  <= w_phase_al;
        end
    end

    assign w_hue = r_scaled + r_phase;
    assign w_h6  = ({3'b000, w_hue} << 2) + ({3'b000, w_hue} << 1);

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_v1) begin
            if (r_palette == hrgb_pkg::PAL_RAINBOW) begin
                r_sector <= w_hue[HFB-1 -: 3];
                r_frac   <= {w_hue[HFB-4:0], 3'b000};
            end else begin
                r_sector <= w_h6[HFB +: 3];
                r_frac   <= w_h6[HFB-1:0];
            end
        end
    end

    assign w_f  = LW'(r_frac);
    assign w_up = (w_f << 8) - w_f;
    assign w_dn = LVL_255 - w_up;
    assign w_t  = (w_f << 6) + (w_f << 4) + (w_f << 2) + w_f;
    assign w_w  = w_t << 1;

    always_comb begin
        w_r = '0;
        w_g = '0;
        w_b = '0;
        if (r_palette == hrgb_pkg::PAL_RAINBOW) begin
            case (r_sector)
                hrgb_pkg::SECT_0: begin w_r = LVL_255 - w_t; w_g = w_t; end
                hrgb_pkg::SECT_1: begin w_r = LVL_171; w_g = LVL_85 + w_t; end
                hrgb_pkg::SECT_2: begin w_r = LVL_171 - w_w; w_g = LVL_170 + w_t; end
                hrgb_pkg::SECT_3: begin w_g = LVL_255 - w_t; w_b = w_t; end
                hrgb_pkg::SECT_4: begin w_g = LVL_171 - w_w; w_b = LVL_85 + w_w; end
                hrgb_pkg::SECT_5: begin w_r = w_t; w_b = LVL_255 - w_t; end
                hrgb_pkg::SECT_6: begin w_r = LVL_85 + w_t; w_b = LVL_171 - w_t; end
                default: begin w_r = LVL_170 + w_t; w_b = LVL_85 - w_t; end
            endcase
        end else begin
            case (r_sector)
                hrgb_pkg::SECT_0: begin w_r = LVL_255; w_g = w_up; end
                hrgb_pkg::SECT_1: begin w_r = w_dn; w_g = LVL_255; end
                hrgb_pkg::SECT_2: begin w_g = LVL_255; w_b = w_up; end
                hrgb_pkg::SECT_3: begin w_g = w_dn; w_b = LVL_255; end
                hrgb_pkg::SECT_4: begin w_r = w_up; w_b = LVL_255; end
                default: begin w_r = LVL_255; w_b = w_dn; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3 && r_v2) begin
            r_red   <= w_r[LW-1 -: 16];
            r_green <= w_g[LW-1 -: 16];
            r_blue  <= w_b[LW-1 -: 16];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_blue, r_green, r_red};

`ifndef SYNTHESIS
    // Input is held off only when every stage holds a request.
    a_full_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_out_valid))
        else $error("input held off with an empty pipeline stage");

    // A request in the middle stage is kept while the output is blocked.
    a_mid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_out_valid && !m_axis_tready) |=> r_v2)
        else $error("middle stage dropped a request during a stall");

    // Every channel stays within 0 to 255.0.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_red <= 16'hFF00 && r_green <= 16'hFF00 && r_blue <= 16'hFF00))
        else $error("color level above 255.0");
`endif

endmodule
